FILE: design/pspq_pkg.sv
// Shared constants, types and helpers of the periodic sightline proximity query core.
// Used by pspq_line_pipe and periodic_sightline_proximity_query_core.
// Depends on nothing.
package pspq_pkg;

    // Table size and coordinate width.
    localparam int MAX_LINES    = 64;
    localparam int COORD_BITS   = 24;
    localparam int ADDR_BITS    = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1;

    // Field widths of the request and result items.
    localparam int SLOT_BITS    = 6;
    localparam int AXIS_BITS    = 2;
    localparam int DIST_BITS    = 48;
    localparam int BOX_BITS     = 25;
    localparam int COUNT_BITS   = 7;
    localparam int CFG_IDX_BITS = 2;

    // Stream data widths, padded to whole bytes.
    localparam int IN_RAW_BITS   = SLOT_BITS + AXIS_BITS + 4 * COORD_BITS;
    localparam int IN_DATA_BITS  = ((IN_RAW_BITS + 7) / 8) * 8;
    localparam int OUT_RAW_BITS  = SLOT_BITS + DIST_BITS;
    localparam int OUT_DATA_BITS = ((OUT_RAW_BITS + 7) / 8) * 8;

    // Internal arithmetic widths.
    localparam int WIN_BITS  = COORD_BITS + 3;   // signed window bounds
    localparam int DIFF_BITS = COORD_BITS + 2;   // signed folded distance
    localparam int SQ_BITS   = 2 * DIFF_BITS;
    localparam int SUM_BITS  = SQ_BITS + 1;
    localparam int HH_BITS   = 2 * COORD_BITS;

    // Reset value of the box edge.
    localparam logic [BOX_BITS-1:0] BOX_RESET = BOX_BITS'(64'd1 << COORD_BITS);

    // Command codes carried on the input tuser.
    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // Projection axis codes. Any other code projects like the y axis.
    localparam logic [AXIS_BITS-1:0] AXIS_X = 2'd1;
    localparam logic [AXIS_BITS-1:0] AXIS_Z = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_BITS-1:0] REG_BOX_SIZE   = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_LINE_COUNT = 2'd1;

    typedef logic signed [WIN_BITS-1:0] t_wval;

    // One stored sightline.
    typedef struct packed {
        logic [AXIS_BITS-1:0]  axis;
        logic [COORD_BITS-1:0] cx;
        logic [COORD_BITS-1:0] cy;
        logic [COORD_BITS-1:0] cz;
    } t_line_entry;

    // Periodic window bounds around one particle coordinate.
    typedef struct packed {
        t_wval hi;        // wrapped upper bound of the half-open window
        t_wval lo;        // wrapped lower bound of the half-open window
        t_wval hi_raw;    // coordinate plus radius
        t_wval lo_raw;    // coordinate minus radius
        t_wval hi_lim;    // upper bound minus box
        t_wval lo_lim;    // lower bound plus box
        logic  hi_over;   // upper bound lies beyond the box
        logic  lo_under;  // lower bound lies below zero
    } t_win;

    // Per-line result leaving the evaluation pipeline.
    typedef struct packed {
        logic                 valid;
        logic                 match;
        logic [SLOT_BITS-1:0] index;
        logic [SUM_BITS-1:0]  dsum;
    } t_line_res;

    // Zero-extends a coordinate into the signed window width.
    function automatic t_wval to_wval(input logic [COORD_BITS-1:0] v);
        return $signed({{(WIN_BITS - COORD_BITS){1'b0}}, v});
    endfunction

    // Zero-extends the box edge into the signed window width.
    function automatic t_wval box_wval(input logic [BOX_BITS-1:0] b);
        return $signed({{(WIN_BITS - BOX_BITS){1'b0}}, b});
    endfunction

    // Builds the periodic window set from the raw bounds.
    function automatic t_win make_win(input t_wval hi_raw, input t_wval lo_raw,
                                      input t_wval boxv);
        t_win w;
        w.hi_raw   = hi_raw;
        w.lo_raw   = lo_raw;
        w.hi_over  = hi_raw > boxv;
        w.lo_under = lo_raw < 0;
        w.hi_lim   = hi_raw - boxv;
        w.lo_lim   = lo_raw + boxv;
        w.hi       = w.hi_over ? w.hi_lim : hi_raw;
        w.lo       = w.lo_under ? w.lo_lim : lo_raw;
        return w;
    endfunction

endpackage

FILE: design/pspq_line_pipe.sv
// Three-stage evaluation pipeline for one stored sightline per advancing cycle.
// Window tests, periodic distance folding, squaring and the radius compare.
// Depends on pspq_pkg.
module pspq_line_pipe (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_adv,
    input  logic                           i_valid,
    input  logic [pspq_pkg::SLOT_BITS-1:0] i_index,
    input  pspq_pkg::t_line_entry          i_entry,
    input  pspq_pkg::t_win                 i_win_x,
    input  pspq_pkg::t_win                 i_win_y,
    input  pspq_pkg::t_win                 i_win_z,
    input  logic [pspq_pkg::COORD_BITS-1:0] i_px,
    input  logic [pspq_pkg::COORD_BITS-1:0] i_py,
    input  logic [pspq_pkg::COORD_BITS-1:0] i_pz,
    input  logic [pspq_pkg::BOX_BITS-1:0]  i_box,
    input  logic [pspq_pkg::HH_BITS-1:0]   i_hh,
    output pspq_pkg::t_line_res            o_res,
    output logic                           o_busy
);
    import pspq_pkg::*;

    typedef logic signed [DIFF_BITS-1:0] t_diff;

    // Folds a signed difference onto the nearest periodic image.
    function automatic t_diff fold(input t_diff d, input t_wval boxv);
        t_wval ext;
        t_wval mag;
        t_wval twice;
        t_wval alt;
        ext   = WIN_BITS'(d);
        mag   = (ext < 0) ? -ext : ext;
        twice = mag <<< 1;
        alt   = boxv - mag;
        return (twice > boxv) ? alt[DIFF_BITS-1:0] : mag[DIFF_BITS-1:0];
    endfunction

    logic                  sel_fy;
    logic                  sel_sy;
    logic [COORD_BITS-1:0] f_p;
    logic [COORD_BITS-1:0] f_c;
    logic [COORD_BITS-1:0] s_p;
    logic [COORD_BITS-1:0] s_c;
    t_win                  win_f;
    t_win                  win_s;
    t_wval                 fcv;
    t_wval                 scv;
    t_wval                 diff_f;
    t_wval                 diff_s;
    t_wval                 boxv;
    logic                  pass_f;
    logic                  pass_s;
    logic [SUM_BITS-1:0]   sum;

    // Stage registers.
    logic                 r_v1, r_v2, r_v3;
    logic [SLOT_BITS-1:0] r_i1, r_i2, r_i3;
    logic                 r_p1, r_p2, r_p3;
    t_diff                r_df, r_ds;
    t_diff                r_af, r_as;
    logic [SQ_BITS-1:0]   r_sqf, r_sqs;

    assign boxv = box_wval(i_box);

    // Stage one: pick the transverse pair by axis and run the window tests.
    always_comb begin
        sel_fy = (i_entry.axis == AXIS_X);
        sel_sy = (i_entry.axis == AXIS_Z);
        f_p    = sel_fy ? i_py : i_px;
        f_c    = sel_fy ? i_entry.cy : i_entry.cx;
        win_f  = sel_fy ? i_win_y : i_win_x;
        s_p    = sel_sy ? i_py : i_pz;
        s_c    = sel_sy ? i_entry.cy : i_entry.cz;
        win_s  = sel_sy ? i_win_y : i_win_z;
        fcv    = to_wval(f_c);
        scv    = to_wval(s_c);
        if (win_f.lo <= win_f.hi) begin
            pass_f = (fcv >= win_f.lo) && (fcv < win_f.hi);
        end else begin
            pass_f = (fcv < win_f.hi) || (fcv >= win_f.lo);
        end
        pass_s = (win_s.hi_over && (scv < win_s.hi_lim))
              || (win_s.lo_under && (scv > win_s.lo_lim))
              || ((scv > win_s.lo_raw) && (scv < win_s.hi_raw));
        diff_f = to_wval(f_p) - fcv;
        diff_s = to_wval(s_p) - scv;
    end

    // Stage four, combinational on the last registers: sum and radius compare.
    assign sum = {1'b0, r_sqf} + {1'b0, r_sqs};

    always_comb begin
        o_res.valid = r_v3;
        o_res.match = r_p3 && (sum <= SUM_BITS'(i_hh));
        o_res.index = r_i3;
        o_res.dsum  = sum;
    end

    assign o_busy = r_v1 | r_v2 | r_v3;

    // Valid bits of the three stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (i_adv) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    // Stage payloads: differences, folded distances, squares.
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_i1  <= i_index;
            r_p1  <= pass_f && pass_s;
            r_df  <= diff_f[DIFF_BITS-1:0];
            r_ds  <= diff_s[DIFF_BITS-1:0];
            r_i2  <= r_i1;
            r_p2  <= r_p1;
            r_af  <= fold(r_df, boxv);
            r_as  <= fold(r_ds, boxv);
            r_i3  <= r_i2;
            r_p3  <= r_p2;
            r_sqf <= r_af * r_af;
            r_sqs <= r_as * r_as;
        end
    end

endmodule

FILE: design/periodic_sightline_proximity_query_core.sv
// Top level of the periodic sightline proximity query core: sightline table,
// query sequencer, result hold and stream output. Depends on pspq_pkg and
// pspq_line_pipe.
//
//   Channel    Direction  Handshake              Payload
//   s_axis     in         tvalid / tready        tdata: slot, axis, x, y, z, radius
//                                                tuser: command (load or query)
//   m_axis     out        tvalid / tready        tdata: line index, squared distance
//                                                tuser: hit, tlast: final result
//   cfg        in         valid / ready          index, data (box size, line count)
//
// A load request writes one table entry. A query request passes through the
// accept, the window setup in the prepare and window states, one table read per
// line through the single memory read port, the drain of the pipeline and the
// final result. Reset is synchronous and active low; the table is not cleared. A
// stalled output freezes the whole scan pipeline, and no request is taken until
// the query's final result has been placed in the output register.
module periodic_sightline_proximity_query_core (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // Request stream.
    input  logic                                 i_s_axis_tvalid,
    output logic                                 o_s_axis_tready,
    // tdata: line_slot[5:0], line_axis[7:6], coord_x[31:8], coord_y[55:32],
    //        coord_z[79:56], radius[103:80]
    input  logic [pspq_pkg::IN_DATA_BITS-1:0]    i_s_axis_tdata,
    // tuser: cmd[0]
    input  logic                                 i_s_axis_tuser,
    // Result stream.
    output logic                                 o_m_axis_tvalid,
    input  logic                                 i_m_axis_tready,
    // tdata: line_index[5:0], dist_sq[53:6], zero pad[55:54]
    output logic [pspq_pkg::OUT_DATA_BITS-1:0]   o_m_axis_tdata,
    // tuser: hit[0]
    output logic                                 o_m_axis_tuser,
    output logic                                 o_m_axis_tlast,
    // Configuration writes.
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [pspq_pkg::CFG_IDX_BITS-1:0]    i_cfg_index,
    input  logic [pspq_pkg::BOX_BITS-1:0]        i_cfg_data
);
    import pspq_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_PREP = 5'b00010,
        ST_WIN  = 5'b00100,
        ST_SCAN = 5'b01000,
        ST_DONE = 5'b10000
    } t_state;

    t_state r_state, n_state;

    // Request fields.
    logic [SLOT_BITS-1:0]  in_slot;
    logic [AXIS_BITS-1:0]  in_axis;
    logic [COORD_BITS-1:0] in_x, in_y, in_z, in_h;
    logic                  in_accept;
    logic                  load_we;
    t_line_entry           in_entry;

    // Configuration registers.
    logic [BOX_BITS-1:0]   r_box;
    logic [COUNT_BITS-1:0] r_line_count;

    // Query registers.
    logic [COORD_BITS-1:0] r_px, r_py, r_pz, r_h;
    logic [HH_BITS-1:0]    r_hh;
    t_wval                 r_hi_x, r_hi_y, r_hi_z, r_lo_x, r_lo_y, r_lo_z;
    t_win                  r_win_x, r_win_y, r_win_z;
    logic [COUNT_BITS-1:0] r_n;
    logic [COUNT_BITS-1:0] r_scan_idx;

    // Sightline table and its registered read port.
    t_line_entry           r_line_mem [MAX_LINES];
    t_line_entry           r_rd_entry;
    logic                  r_v0;
    logic [SLOT_BITS-1:0]  r_i0;

    // Pending match and output register.
    t_line_res             r_pend;
    logic                  r_pend_valid;
    logic                  r_out_valid;
    logic [SLOT_BITS-1:0]  r_out_index;
    logic [DIST_BITS-1:0]  r_out_dist;
    logic                  r_out_hit;
    logic                  r_out_last;

    logic                  adv;
    logic                  issue;
    logic                  flush;
    logic                  take_match;
    logic                  emit_mid;
    t_line_res             pipe_res;
    logic                  pipe_busy;
    t_wval                 boxv;

    // Unpack the request.
    always_comb begin
        {in_h, in_z, in_y, in_x, in_axis, in_slot} = i_s_axis_tdata[IN_RAW_BITS-1:0];
        in_entry.axis = in_axis;
        in_entry.cx   = in_x;
        in_entry.cy   = in_y;
        in_entry.cz   = in_z;
    end

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign in_accept       = i_s_axis_tvalid && o_s_axis_tready;
    assign load_we         = in_accept && (i_s_axis_tuser == CMD_LOAD)
                          && ({1'b0, in_slot} < COUNT_BITS'(MAX_LINES));
    assign o_cfg_ready     = 1'b1;
    assign boxv            = box_wval(r_box);

    // Configuration register writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_box        <= BOX_RESET;
            r_line_count <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_BOX_SIZE:   r_box        <= i_cfg_data;
                REG_LINE_COUNT: r_line_count <= i_cfg_data[COUNT_BITS-1:0];
                default:        ;
            endcase
        end
    end

    // Pipeline handshake: everything moves when the output register can take a result.
    assign adv        = !r_out_valid || i_m_axis_tready;
    assign issue      = (r_state == ST_SCAN) && (r_scan_idx < r_n);
    assign flush      = (r_state == ST_DONE) && adv && !r_v0 && !pipe_busy;
    assign take_match = adv && pipe_res.valid && pipe_res.match;
    assign emit_mid   = take_match && r_pend_valid;

    // Sequencer.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: if (in_accept && (i_s_axis_tuser == CMD_QUERY)) n_state = ST_PREP;
            ST_PREP: n_state = ST_WIN;
            ST_WIN:  n_state = ST_SCAN;
            ST_SCAN: if (!issue) n_state = ST_DONE;
            ST_DONE: if (flush) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Query capture and window setup.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_px <= in_x;
            r_py <= in_y;
            r_pz <= in_z;
            r_h  <= in_h;
            r_n  <= (r_line_count > COUNT_BITS'(MAX_LINES)) ? COUNT_BITS'(MAX_LINES)
                                                             : r_line_count;
        end
        if (r_state == ST_PREP) begin
            r_hh   <= r_h * r_h;
            r_hi_x <= to_wval(r_px) + to_wval(r_h);
            r_hi_y <= to_wval(r_py) + to_wval(r_h);
            r_hi_z <= to_wval(r_pz) + to_wval(r_h);
            r_lo_x <= to_wval(r_px) - to_wval(r_h);
            r_lo_y <= to_wval(r_py) - to_wval(r_h);
            r_lo_z <= to_wval(r_pz) - to_wval(r_h);
        end
        if (r_state == ST_WIN) begin
            r_win_x <= make_win(r_hi_x, r_lo_x, boxv);
            r_win_y <= make_win(r_hi_y, r_lo_y, boxv);
            r_win_z <= make_win(r_hi_z, r_lo_z, boxv);
        end
    end

    // Table write on a load request.
    always_ff @(posedge i_clk) begin
        if (load_we) begin
            r_line_mem[in_slot[ADDR_BITS-1:0]] <= in_entry;
        end
    end

    // Table read, one entry per advancing cycle during the scan.
    always_ff @(posedge i_clk) begin
        if (adv && issue) begin
            r_rd_entry <= r_line_mem[r_scan_idx[ADDR_BITS-1:0]];
            r_i0       <= r_scan_idx[SLOT_BITS-1:0];
        end
    end

    // Scan counter and read valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0       <= 1'b0;
            r_scan_idx <= '0;
        end else begin
            if (in_accept) begin
                r_scan_idx <= '0;
            end else if (adv && issue) begin
                r_scan_idx <= r_scan_idx + 1'b1;
            end
            if (adv) begin
                r_v0 <= issue;
            end
        end
    end

    pspq_line_pipe u_line_pipe (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_valid (r_v0),
        .i_index (r_i0),
        .i_entry (r_rd_entry),
        .i_win_x (r_win_x),
        .i_win_y (r_win_y),
        .i_win_z (r_win_z),
        .i_px    (r_px),
        .i_py    (r_py),
        .i_pz    (r_pz),
        .i_box   (r_box),
        .i_hh    (r_hh),
        .o_res   (pipe_res),
        .o_busy  (pipe_busy)
    );

    // Hold the newest match until it is known whether it is the query's last.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_valid <= 1'b0;
        end else if (in_accept || flush) begin
            r_pend_valid <= 1'b0;
        end else if (take_match) begin
            r_pend_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take_match) begin
            r_pend <= pipe_res;
        end
    end

    // Output register valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit_mid || flush) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output payload: an earlier match, or the final result of the query.
    always_ff @(posedge i_clk) begin
        if (emit_mid) begin
            r_out_index <= r_pend.index;
            r_out_dist  <= r_pend.dsum[DIST_BITS-1:0];
            r_out_hit   <= 1'b1;
            r_out_last  <= 1'b0;
        end else if (flush) begin
            r_out_index <= r_pend_valid ? r_pend.index : '0;
            r_out_dist  <= r_pend_valid ? r_pend.dsum[DIST_BITS-1:0] : '0;
            r_out_hit   <= r_pend_valid;
            r_out_last  <= 1'b1;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {{(OUT_DATA_BITS - OUT_RAW_BITS){1'b0}}, r_out_dist, r_out_index};
    assign o_m_axis_tuser  = r_out_hit;
    assign o_m_axis_tlast  = r_out_last;

endmodule
